### rtl/fwrr_pkg.sv
package fwrr_pkg;

  // fixed field widths and the default entry count
  localparam int OP_W            = 2;
  localparam int IDX_FIELD_W     = 10;
  localparam int DATA_W          = 32;
  localparam int DEFAULT_ENTRIES = 1024;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SUM   = 2'd1,
    OP_POINT = 2'd2
  } op_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_A_MUL,
    S_A_LOADA,
    S_A_WALKA,
    S_A_LOADB,
    S_A_WALKB,
    S_Q1_LOAD,
    S_Q1_WALK,
    S_Q1_MUL,
    S_Q1_COMB,
    S_Q2_LOAD,
    S_Q2_WALK,
    S_Q2_MUL,
    S_Q2_COMB
  } state_t;

  // start point of a prefix walk
  typedef enum logic [1:0] {
    POS_HI,
    POS_LO,
    POS_LO_M1
  } pos_sel_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_D_LO,
    MUL_D_HI1,
    MUL_ACC_N
  } mul_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     clear_en;
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load_a;
    logic     load_b;
    logic     add_step;
    logic     q_load;
    pos_sel_t pos_sel;
    logic     q_step;
    logic     comb_first;
    logic     comb_second;
    logic     set_point;
    logic     out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic            clear_done;
    logic            bad;
    logic [OP_W-1:0] op;
    logic            lo_zero;
    logic            walk_end;
    logic            qwalk_done;
  } stat_t;

endpackage

### rtl/fwrr_req_if.sv
interface fwrr_req_if;
  import fwrr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic        [OP_W-1:0]        operation;
  logic        [IDX_FIELD_W-1:0] range_low;
  logic        [IDX_FIELD_W-1:0] range_high;
  logic signed [DATA_W-1:0]      delta;

  modport source (output valid, operation, range_low, range_high, delta, input ready);
  modport sink   (input valid, operation, range_low, range_high, delta, output ready);

endinterface

### rtl/fwrr_rsp_if.sv
interface fwrr_rsp_if;
  import fwrr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);

endinterface

### rtl/fwrr_ctrl.sv
module fwrr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  fwrr_pkg::stat_t st,
  output fwrr_pkg::cmd_t  cmd
);
  import fwrr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;

  // state register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (st.clear_done) state_next = S_IDLE;
      S_IDLE:    if (req_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (st.bad) begin
          state_next = S_Q2_COMB;
        end else if (st.op == OP_ADD) begin
          state_next = S_A_MUL;
        end else begin
          state_next = S_Q1_LOAD;
        end
      end
      S_A_MUL:   state_next = S_A_LOADA;
      S_A_LOADA: state_next = S_A_WALKA;
      S_A_WALKA: if (st.walk_end) state_next = S_A_LOADB;
      S_A_LOADB: state_next = S_A_WALKB;
      S_A_WALKB: if (st.walk_end) state_next = S_Q2_COMB;
      S_Q1_LOAD: state_next = S_Q1_WALK;
      S_Q1_WALK: begin
        if (st.qwalk_done) begin
          state_next = (st.op == OP_POINT) ? S_Q2_COMB : S_Q1_MUL;
        end
      end
      S_Q1_MUL:  state_next = S_Q1_COMB;
      S_Q1_COMB: state_next = st.lo_zero ? S_Q2_COMB : S_Q2_LOAD;
      S_Q2_LOAD: state_next = S_Q2_WALK;
      S_Q2_WALK: if (st.qwalk_done) state_next = S_Q2_MUL;
      S_Q2_MUL:  state_next = S_Q2_COMB;
      S_Q2_COMB: if (cmd.out_load) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  // S_Q2_COMB doubles as the result hand-off state; the second combine
  // only applies for a two-sided range sum, gated by a one-shot flag
  logic comb2_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      comb2_done <= 1'b0;
    end else if (state == S_Q2_COMB) begin
      comb2_done <= !(cmd.out_load);
    end else begin
      comb2_done <= 1'b0;
    end
  end

  logic two_sided;
  always_ff @(posedge clk) begin
    if (rst) begin
      two_sided <= 1'b0;
    end else if (state == S_Q2_MUL) begin
      two_sided <= 1'b1;
    end else if (state == S_IDLE) begin
      two_sided <= 1'b0;
    end
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_D_LO;
    cmd.pos_sel = POS_HI;
    req_ready   = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_en = 1'b1;
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_A_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D_LO;
      end
      S_A_LOADA: begin
        cmd.load_a  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D_HI1;
      end
      S_A_WALKA: cmd.add_step = 1'b1;
      S_A_LOADB: cmd.load_b   = 1'b1;
      S_A_WALKB: cmd.add_step = 1'b1;
      S_Q1_LOAD: begin
        cmd.q_load  = 1'b1;
        cmd.pos_sel = (st.op == OP_POINT) ? POS_LO : POS_HI;
      end
      S_Q1_WALK: begin
        cmd.q_step    = 1'b1;
        cmd.set_point = st.qwalk_done && (st.op == OP_POINT);
      end
      S_Q1_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC_N;
      end
      S_Q1_COMB: cmd.comb_first = 1'b1;
      S_Q2_LOAD: begin
        cmd.q_load  = 1'b1;
        cmd.pos_sel = POS_LO_M1;
      end
      S_Q2_WALK: cmd.q_step = 1'b1;
      S_Q2_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ACC_N;
      end
      S_Q2_COMB: begin
        // for a two-sided sum combine once on entry, then hand the result off
        if (two_sided && !comb2_done) begin
          cmd.comb_second = 1'b1;
        end else begin
          cmd.out_load = !out_valid || rsp_ready;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign rsp_valid = out_valid;

endmodule

### rtl/fwrr_dp.sv
module fwrr_dp #(
  parameter int ENTRIES = fwrr_pkg::DEFAULT_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fwrr_pkg::cmd_t                         cmd,
  input  logic        [fwrr_pkg::OP_W-1:0]        operation,
  input  logic        [fwrr_pkg::IDX_FIELD_W-1:0] range_low,
  input  logic        [fwrr_pkg::IDX_FIELD_W-1:0] range_high,
  input  logic signed [fwrr_pkg::DATA_W-1:0]      delta,
  output fwrr_pkg::stat_t                        st,
  output logic signed [fwrr_pkg::DATA_W-1:0]      value,
  output logic                                   status
);
  import fwrr_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int KX_W  = IDX_W + 2;
  localparam int MB_W  = (KX_W > IDX_FIELD_W + 1) ? KX_W : IDX_FIELD_W + 1;

  // captured item
  logic [OP_W-1:0]        op;
  logic [IDX_FIELD_W-1:0] lo;
  logic [IDX_FIELD_W-1:0] hi;
  logic [DATA_W-1:0]      d;

  // walk state
  logic [KX_W-1:0]   k;
  logic [KX_W-1:0]   qn;
  logic [KX_W-1:0]   k_low;
  logic [KX_W-1:0]   k_m1;
  logic              k_ok;
  logic              q_ok;
  logic              pend;
  logic [IDX_W-1:0]  pend_addr;
  logic              rv;
  logic [DATA_W-1:0] amt_v;
  logic [DATA_W-1:0] amt_c;
  logic [DATA_W-1:0] acc_v;
  logic [DATA_W-1:0] acc_c;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] res;
  logic [IDX_W-1:0]  clr_cnt;
  logic              bad;

  // tree memories
  logic [DATA_W-1:0] mem_v [ENTRIES];
  logic [DATA_W-1:0] mem_c [ENTRIES];
  logic [DATA_W-1:0] rdata_v;
  logic [DATA_W-1:0] rdata_c;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] wdata_v;
  logic [DATA_W-1:0] wdata_c;

  // multiplier
  logic [DATA_W-1:0]      mul_a;
  logic [MB_W-1:0]        mul_b;
  logic [DATA_W+MB_W-1:0] mul_full;
  logic [KX_W-1:0]        k_load;

  // range checks on the captured item
  always_comb begin
    case (op)
      OP_ADD, OP_SUM: bad = (lo > hi) || (32'(hi) >= 32'(ENTRIES));
      OP_POINT:       bad = 32'(lo) >= 32'(ENTRIES);
      default:        bad = 1'b1;
    endcase
  end

  assign k_low = k & (~k + KX_W'(1));
  assign k_m1  = k - KX_W'(1);
  assign k_ok  = (k != '0) && (k <= KX_W'(ENTRIES));
  assign q_ok  = (k != '0);

  assign st.clear_done = (clr_cnt == IDX_W'(ENTRIES - 1));
  assign st.bad        = bad;
  assign st.op         = op;
  assign st.lo_zero    = (lo == '0);
  assign st.walk_end   = !k_ok;
  assign st.qwalk_done = !q_ok && !rv;

  // memory port selection
  assign raddr   = k_m1[IDX_W-1:0];
  assign we      = cmd.clear_en || (cmd.add_step && pend);
  assign waddr   = cmd.clear_en ? clr_cnt : pend_addr;
  assign wdata_v = cmd.clear_en ? '0 : rdata_v + amt_v;
  assign wdata_c = cmd.clear_en ? '0 : rdata_c + amt_c;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_v[waddr] <= wdata_v;
      mem_c[waddr] <= wdata_c;
    end
    rdata_v <= mem_v[raddr];
    rdata_c <= mem_c[raddr];
  end

  // multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_D_LO: begin
        mul_a = d;
        mul_b = MB_W'(lo);
      end
      MUL_D_HI1: begin
        mul_a = d;
        mul_b = MB_W'(hi) + MB_W'(1);
      end
      MUL_ACC_N: begin
        mul_a = acc_v;
        mul_b = MB_W'(qn);
      end
      default: begin
        mul_a = d;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = {{MB_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};

  // start position of a prefix walk
  always_comb begin
    case (cmd.pos_sel)
      POS_HI:    k_load = KX_W'(hi) + KX_W'(1);
      POS_LO:    k_load = KX_W'(lo) + KX_W'(1);
      POS_LO_M1: k_load = KX_W'(lo);
      default:   k_load = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pend    <= 1'b0;
      rv      <= 1'b0;
    end else begin
      if (cmd.clear_en) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (cmd.load_a || cmd.load_b) begin
        pend <= 1'b0;
      end else if (cmd.add_step) begin
        pend <= k_ok;
      end
      if (cmd.q_load) begin
        rv <= 1'b0;
      end else if (cmd.q_step) begin
        rv <= q_ok;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= operation;
      lo  <= range_low;
      hi  <= range_high;
      d   <= delta;
      res <= '0;
    end

    if (cmd.mul_en) begin
      prod <= mul_full[DATA_W-1:0];
    end

    // add walks: read this position, write the previous one
    if (cmd.load_a) begin
      k     <= KX_W'(lo) + KX_W'(1);
      amt_v <= d;
      amt_c <= prod;
    end else if (cmd.load_b) begin
      k     <= KX_W'(hi) + KX_W'(2);
      amt_v <= '0 - d;
      amt_c <= '0 - prod;
    end else if (cmd.add_step && k_ok) begin
      k         <= k + k_low;
      pend_addr <= raddr;
    end

    // prefix walks: accumulate both trees together
    if (cmd.q_load) begin
      k     <= k_load;
      qn    <= k_load;
      acc_v <= '0;
      acc_c <= '0;
    end else if (cmd.q_step) begin
      if (q_ok) begin
        k <= k - k_low;
      end
      if (rv) begin
        acc_v <= acc_v + rdata_v;
        acc_c <= acc_c + rdata_c;
      end
    end

    // result assembly
    if (cmd.comb_first) begin
      res <= prod - acc_c;
    end else if (cmd.comb_second) begin
      res <= res - (prod - acc_c);
    end else if (cmd.set_point) begin
      res <= acc_v + (rv ? rdata_v : '0);
    end

    if (cmd.out_load) begin
      value  <= bad ? '0 : res;
      status <= bad;
    end
  end

endmodule

### rtl/fenwick_range_add_range_sum.sv
// range add, range sum and point query over ENTRIES words kept as two binary
// indexed trees; one item at a time, the rate set by the tree walks, one step
// a cycle on the single read and write port of each tree memory, both trees
// in parallel; after reset a clearing pass zeroes every entry of both trees
// before the first transaction is taken
module fenwick_range_add_range_sum #(
  parameter int ENTRIES = fwrr_pkg::DEFAULT_ENTRIES
) (
  input logic       clk,
  input logic       rst,
  fwrr_req_if.sink  req,
  fwrr_rsp_if.source rsp
);
  import fwrr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer
  fwrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // trees, walk registers and arithmetic
  fwrr_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (req.operation),
    .range_low  (req.range_low),
    .range_high (req.range_high),
    .delta      (req.delta),
    .st         (st),
    .value      (rsp.value),
    .status     (rsp.status)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import fwrr_pkg::*;

  localparam int ENTRIES = DEFAULT_ENTRIES;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_BAD = 1'b1;
  localparam int CYCLE_LIMIT = 1_000_000;
  // longest walk (range sum) plus margin
  localparam int DRAIN_CYCLES = 2 * $clog2(ENTRIES) + 30;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_NORMAL,
    IDLE_HEAVY
  } idle_mode_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              status;
  } answer_t;

  logic clk = 1'b0;
  logic rst;

  fwrr_req_if req ();
  fwrr_rsp_if rsp ();

  fenwick_range_add_range_sum #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow copies of both trees
  logic [DATA_W-1:0] value_tree [ENTRIES];
  logic [DATA_W-1:0] corr_tree [ENTRIES];

  answer_t     pending_answers [$];
  idle_mode_t  req_idle;
  idle_mode_t  rsp_idle;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rsp_stall_left = 0;

  always #5 clk = ~clk;

  // gap lengths: mostly zero or short, a few long
  function automatic int unsigned idle_gap(idle_mode_t mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_NORMAL: begin
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
      end
      IDLE_HEAVY: begin
        if (r < 30) return 0;
        if (r < 70) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(5, 20);
        return $urandom_range(30, 80);
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] low_bit(logic [DATA_W-1:0] k);
    return k & (~k + 1'b1);
  endfunction

  // sum of tree entries covering positions 0..pos
  function automatic logic [DATA_W-1:0] tree_prefix(bit use_corr, logic [DATA_W-1:0] pos);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] k;
    acc = '0;
    k = pos + 1;
    while (k != 0) begin
      if (k <= ENTRIES) acc += use_corr ? corr_tree[k-1] : value_tree[k-1];
      k -= low_bit(k);
    end
    return acc;
  endfunction

  // point update; positions past the end touch nothing
  function automatic void tree_add(bit use_corr, logic [DATA_W-1:0] pos,
                                   logic [DATA_W-1:0] amount);
    logic [DATA_W-1:0] k;
    k = pos + 1;
    while (k != 0 && k <= ENTRIES) begin
      if (use_corr) corr_tree[k-1] += amount;
      else value_tree[k-1] += amount;
      k += low_bit(k);
    end
  endfunction

  // sum of elements 0..pos
  function automatic logic [DATA_W-1:0] prefix_total(logic [DATA_W-1:0] pos);
    return tree_prefix(1'b0, pos) * (pos + 1) - tree_prefix(1'b1, pos);
  endfunction

  // update the shadow trees and work out the answer of one transaction
  function automatic answer_t apply_to_trees(logic [OP_W-1:0] op,
                                             logic [IDX_FIELD_W-1:0] lo, hi,
                                             logic [DATA_W-1:0] d);
    answer_t           ans;
    logic [DATA_W-1:0] lo_w;
    logic [DATA_W-1:0] hi_w;
    logic [DATA_W-1:0] hi1_w;
    ans = '0;
    ans.status = STATUS_DONE;
    lo_w = DATA_W'(lo);
    hi_w = DATA_W'(hi);
    hi1_w = hi_w + 1;
    case (op)
      OP_ADD, OP_SUM: begin
        if (lo > hi || hi >= ENTRIES) begin
          ans.status = STATUS_BAD;
        end else if (op == OP_ADD) begin
          tree_add(1'b0, lo_w, d);
          tree_add(1'b0, hi1_w, -d);
          if (lo != 0) tree_add(1'b1, lo_w, d * lo_w);
          tree_add(1'b1, hi1_w, -(d * hi1_w));
        end else begin
          ans.value = prefix_total(hi_w);
          if (lo != 0) ans.value -= prefix_total(lo_w - 1);
        end
      end
      OP_POINT: begin
        if (lo >= ENTRIES) ans.status = STATUS_BAD;
        else ans.value = tree_prefix(1'b0, lo_w);
      end
      default: ans.status = STATUS_BAD;
    endcase
    return ans;
  endfunction

  function automatic void note_mismatch(string what, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb: %s mismatch at %0t: expected %h, got %h", what, $time, exp_v, act_v);
  endfunction

  // one request transaction, driven on the falling edge
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_FIELD_W-1:0] lo, hi,
                           logic [DATA_W-1:0] d);
    int unsigned gap;
    gap = idle_gap(req_idle);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.range_low <= lo;
    req.range_high <= hi;
    req.delta <= d;
    do @(posedge clk); while (!req.ready);
    pending_answers.push_back(apply_to_trees(op, lo, hi, d));
    @(negedge clk);
  endtask

  function automatic logic [IDX_FIELD_W-1:0] random_index();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return IDX_FIELD_W'($urandom_range(0, ENTRIES - 1));
    if (r < 7) return IDX_FIELD_W'($urandom_range(0, 15));
    if (r < 9) return IDX_FIELD_W'($urandom_range(ENTRIES - 16, ENTRIES - 1));
    return $urandom_range(0, 1) ? IDX_FIELD_W'(ENTRIES - 1) : '0;
  endfunction

  function automatic logic [DATA_W-1:0] random_delta();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return DATA_W'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      default: return '0;
    endcase
  endfunction

  // mostly well-formed ranges, some reversed ones and unused codes
  task automatic send_random_item();
    int unsigned            pick;
    logic [OP_W-1:0]        op;
    logic [IDX_FIELD_W-1:0] lo;
    logic [IDX_FIELD_W-1:0] hi;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_ADD;
    else if (pick < 75) op = OP_SUM;
    else if (pick < 95) op = OP_POINT;
    else op = OP_UNUSED;
    lo = random_index();
    hi = random_index();
    if (lo > hi && $urandom_range(0, 9) != 0) {lo, hi} = {hi, lo};
    send_item(op, lo, hi, random_delta());
  endtask

  task automatic test_directed();
    req_idle = IDLE_NORMAL;
    rsp_idle = IDLE_NORMAL;
    // cleared trees
    send_item(OP_POINT, 10'd0, 10'd0, '0);
    send_item(OP_SUM, 10'd0, 10'd1023, '0);
    // full range, last element and first element; walks past the end
    send_item(OP_ADD, 10'd0, 10'd1023, 32'h7fff_ffff);
    send_item(OP_ADD, 10'd1023, 10'd1023, 32'h8000_0000);
    send_item(OP_ADD, 10'd0, 10'd0, 32'hffff_ffff);
    send_item(OP_ADD, 10'h155, 10'h2aa, 32'h1234_5678);
    send_item(OP_ADD, 10'h2aa, 10'h3fe, 32'hedcb_a987);
    send_item(OP_ADD, 10'd512, 10'd512, '0);
    send_item(OP_ADD, 10'd1, 10'd1, 32'h0000_0001);
    send_item(OP_SUM, 10'd0, 10'd1023, '1);
    send_item(OP_SUM, 10'd0, 10'd0, '0);
    send_item(OP_SUM, 10'd1023, 10'd1023, '0);
    send_item(OP_SUM, 10'h155, 10'h2aa, '0);
    send_item(OP_SUM, 10'd1, 10'd1022, '0);
    send_item(OP_SUM, 10'd511, 10'd513, '0);
    send_item(OP_SUM, 10'd0, 10'd1, '0);
    // point query ignores the high index
    send_item(OP_POINT, 10'd1023, 10'd0, '0);
    send_item(OP_POINT, 10'h2aa, 10'h155, '0);
    send_item(OP_POINT, 10'h155, 10'h3ff, 32'hffff_ffff);
    send_item(OP_POINT, 10'd512, 10'd0, '0);
    // reversed ranges and the unused code change nothing
    send_item(OP_ADD, 10'd5, 10'd4, 32'h5555_5555);
    send_item(OP_SUM, 10'd1023, 10'd0, '0);
    send_item(OP_UNUSED, 10'd0, 10'd1023, 32'h2222_2222);
    send_item(OP_SUM, 10'd0, 10'd1023, '0);
  endtask

  task automatic test_random_traffic(int unsigned count);
    req_idle = IDLE_NORMAL;
    rsp_idle = IDLE_NORMAL;
    repeat (count) send_random_item();
  endtask

  task automatic test_back_to_back(int unsigned count);
    req_idle = IDLE_NONE;
    rsp_idle = IDLE_NONE;
    repeat (count) send_random_item();
  endtask

  task automatic test_heavy_stall(int unsigned count);
    req_idle = IDLE_HEAVY;
    rsp_idle = IDLE_HEAVY;
    repeat (count) send_random_item();
  endtask

  // response back-pressure
  always @(negedge clk) begin
    if (rsp_stall_left != 0) begin
      rsp.ready <= 1'b0;
      rsp_stall_left--;
    end else begin
      rsp.ready <= 1'b1;
      rsp_stall_left = idle_gap(rsp_idle);
    end
  end

  // compare each response transaction with the oldest pending answer
  always @(posedge clk) begin : check_rsp
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        note_mismatch("unexpected response", '0, rsp.value);
      end else begin
        want = pending_answers.pop_front();
        if (rsp.value !== want.value) note_mismatch("value", want.value, rsp.value);
        if (rsp.status !== want.status)
          note_mismatch("status", DATA_W'(want.status), DATA_W'(rsp.status));
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = OP_ADD;
    req.range_low = '0;
    req.range_high = '0;
    req.delta = '0;
    rsp.ready = 1'b0;
    req_idle = IDLE_NORMAL;
    rsp_idle = IDLE_NORMAL;
    for (int i = 0; i < ENTRIES; i++) begin
      value_tree[i] = '0;
      corr_tree[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(900);
    test_back_to_back(250);
    test_heavy_stall(180);

    // drain
    req.valid <= 1'b0;
    rsp_idle = IDLE_NORMAL;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
